// ===== rtl/sbdt_pkg.sv =====
package sbdt_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 16;
	localparam int DIST_WIDTH  = VALUE_WIDTH + 1;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic        [DIST_WIDTH-1:0]  dist_t;

	// one slot of the ordered list
	typedef struct packed {
		logic   valid;
		value_t value;
		dist_t  distance;
	} entry_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic insert;   // place the new element this cycle
		logic shift;    // move the whole row one cell toward the head
	} cell_ctrl_t;

endpackage

// ===== rtl/sbdt_cell.sv =====
module sbdt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sbdt_pkg::cell_ctrl_t ctrl,
	input  sbdt_pkg::value_t   new_value,
	input  sbdt_pkg::dist_t    new_dist,
	input  logic               left_take,
	input  sbdt_pkg::entry_t   left_entry,
	input  sbdt_pkg::entry_t   right_entry,
	output logic               take,
	output sbdt_pkg::entry_t   entry
);

	logic              valid_q;
	sbdt_pkg::value_t  value_q;
	sbdt_pkg::dist_t   dist_q;

	// strict compare keeps equal distances in arrival order
	assign take  = !valid_q || (dist_q > new_dist);
	assign entry = '{valid: valid_q, value: value_q, distance: dist_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert && take) begin
			valid_q <= left_take ? left_entry.valid : 1'b1;
		end else if (ctrl.shift) begin
			valid_q <= right_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && take) begin
			if (left_take) begin
				value_q <= left_entry.value;
				dist_q  <= left_entry.distance;
			end else begin
				value_q <= new_value;
				dist_q  <= new_dist;
			end
		end else if (ctrl.shift) begin
			value_q <= right_entry.value;
			dist_q  <= right_entry.distance;
		end
	end

endmodule

// ===== rtl/sort_by_distance_to_target.sv =====
// Stable sort of a set of signed values by absolute distance to a target.
//
// Input stream (s_axis_*): one value per beat, s_axis_tlast on the final
// value of a set. Each beat is inserted into a row of
// CAPACITY cells kept ordered by |value - target|; equal distances stay in
// arrival order. A non-last beat produces no output.
// On the last beat the row turns into a drain: the next cycle the head cell
// is shown on m_axis_*, and every accepted output beat shifts the row one
// cell toward the head. m_axis_tlast marks the final stored value and
// m_axis_tuser (dropped) is set on every beat of a set in which a value was
// discarded because all CAPACITY cells were full.
// Throughput: one input beat per cycle while collecting; one output beat
// per cycle while draining and m_axis_tready is high. s_axis_tready is
// low during the drain, so a new set starts once the previous one is
// fully delivered. If the receiver stalls, the row holds.
// target is written through target_we/target_wdata, by the user only while
// idle (not enforced); stored entries keep the distance computed at arrival.
// Reset clears all cell valid bits, the drop flag, the drain flag and
// sets target to zero; no clearing pass is needed.
module sort_by_distance_to_target (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        target_we,
	input  logic [15:0] target_wdata,    // target
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // [15:0] value
	input  logic        s_axis_tlast,
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,    // [15:0] value_res
	output logic        m_axis_tlast,
	output logic        m_axis_tuser     // [0] dropped
);

	localparam int N = sbdt_pkg::CAPACITY;
	localparam int W = sbdt_pkg::VALUE_WIDTH;
	localparam int D = sbdt_pkg::DIST_WIDTH;

	sbdt_pkg::value_t     target_q;
	logic                 draining_q;
	logic                 overflow_q;

	sbdt_pkg::cell_ctrl_t ctrl;
	sbdt_pkg::value_t     new_value;
	sbdt_pkg::dist_t      new_dist;
	logic signed [D-1:0]  diff;

	logic                 take   [N];
	sbdt_pkg::entry_t     entry  [N+1];

	logic                 s_beat;
	logic                 m_beat;
	logic                 full;

	// Hold the target.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_we) begin
			target_q <= sbdt_pkg::value_t'(target_wdata);
		end
	end

	// Full-width distance: one extra bit keeps the difference exact.
	assign new_value = sbdt_pkg::value_t'(s_axis_tdata[W-1:0]);
	assign diff      = {new_value[W-1], new_value} - {target_q[W-1], target_q};
	assign new_dist  = diff[D-1] ? sbdt_pkg::dist_t'(-diff) : sbdt_pkg::dist_t'(diff);

	assign s_axis_tready = !draining_q;
	assign s_beat        = s_axis_tvalid && s_axis_tready;
	assign m_beat        = m_axis_tvalid && m_axis_tready;
	assign full          = entry[N-1].valid;

	// Drop an element when every cell is taken.
	assign ctrl.insert = s_beat && !full;
	assign ctrl.shift  = m_beat;

	// Past the tail the row reads as empty.
	assign entry[N] = '{valid: 1'b0, value: '0, distance: '0};

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_head
			sbdt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.new_value  (new_value),
				.new_dist   (new_dist),
				.left_take  (1'b0),
				.left_entry (entry[N]),
				.right_entry(entry[1]),
				.take       (take[0]),
				.entry      (entry[0])
			);
		end else begin : g_body
			sbdt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.new_value  (new_value),
				.new_dist   (new_dist),
				.left_take  (take[i-1]),
				.left_entry (entry[i-1]),
				.right_entry(entry[i+1]),
				.take       (take[i]),
				.entry      (entry[i])
			);
		end
	end

	// Present the head cell while draining.
	assign m_axis_tvalid = draining_q && entry[0].valid;
	assign m_axis_tdata  = 16'(entry[0].value);
	assign m_axis_tlast  = !entry[1].valid;
	assign m_axis_tuser  = overflow_q;

	// Enter drain on the last beat, close the set on the final output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (s_beat && full) begin
				overflow_q <= 1'b1;
			end
			if (s_beat && s_axis_tlast) begin
				draining_q <= 1'b1;
			end
			if (m_beat && m_axis_tlast) begin
				draining_q <= 1'b0;
				overflow_q <= 1'b0;
			end
		end
	end

endmodule
